/* sv/clipped_alpha_rect_fill_engine_top_assert.svh */
// Assertion macros for the fill engine port checker.
// Used by the checker module; needs nothing else.
`ifndef CLIPPED_ALPHA_RECT_FILL_ENGINE_TOP_ASSERT_SVH
`define CLIPPED_ALPHA_RECT_FILL_ENGINE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define CARF_ASSERT_NOW(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("fill engine port check failed");

// Consequent checked in the cycle after the antecedent
`define CARF_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("fill engine port check failed");

`endif

/* sv/carf_pkg.sv */
// Shared types, codes and helpers of the rectangle fill engine.
// No dependencies.
`timescale 1ns / 1ps

package carf_pkg;

    // Command action codes
    localparam logic [1:0] ACT_FILL     = 2'd0;
    localparam logic [1:0] ACT_OUTLINE  = 2'd1;
    localparam logic [1:0] ACT_READ     = 2'd2;
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    // Pixel operation codes between walker and pixel engine
    typedef logic [1:0] t_pix_op;
    localparam t_pix_op OP_WRITE = 2'd0;
    localparam t_pix_op OP_BLEND = 2'd1;
    localparam t_pix_op OP_READ  = 2'd2;

    // Alpha thresholds and blend constants
    localparam logic [7:0]  ALPHA_OPAQUE = 8'd250;
    localparam logic [7:0]  ALPHA_FULL   = 8'd255;
    localparam logic [15:0] DIV_BIAS     = 16'd257;

    typedef struct packed {
        logic [4:0] red;
        logic [5:0] green;
        logic [4:0] blue;
    } t_rgb565;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [11:0] origin_x;
        logic signed [11:0] origin_y;
        logic signed [11:0] rect_width;
        logic signed [11:0] rect_height;
        logic [7:0]         opacity;
    } t_cmd;

    typedef struct packed {
        t_rgb565    color;
        logic [7:0] alpha;
    } t_paint;

    // Walker to pixel engine request
    typedef struct packed {
        logic    valid;
        t_pix_op op;
    } t_pix_ctl;

    // Pixel engine status back to walker and top
    typedef struct packed {
        logic    ready;
        logic    rd_valid;
        t_rgb565 rd_pixel;
    } t_pix_sts;

    // Fast divide by 255 for blend sums below 2^14
    function automatic logic [7:0] div255(input logic [13:0] v);
        logic [15:0] t;
        t = {2'b00, v} + (({2'b00, v} + DIV_BIAS) >> 8);
        return t[15:8];
    endfunction

endpackage

/* sv/carf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module carf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/carf_walk.sv */
// Edge splitting, clipping and raster walk of one command.
// Depends on carf_pkg; feeds carf_pix one pixel word per handshake.
`timescale 1ns / 1ps

module carf_walk #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  carf_pkg::t_cmd                               i_cmd,
    input  carf_pkg::t_pix_sts                           i_pix_sts,
    output logic                                         o_busy,
    output carf_pkg::t_pix_ctl                           o_ctl,
    output logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT)-1:0]  o_addr
);

    localparam int XW = $clog2(FRAME_WIDTH + 1);
    localparam int YW = $clog2(FRAME_HEIGHT + 1);
    localparam int AW = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
    localparam logic signed [14:0] FwS = 15'(FRAME_WIDTH);
    localparam logic signed [14:0] FhS = 15'(FRAME_HEIGHT);

    localparam logic [1:0] W_IDLE = 2'd0;
    localparam logic [1:0] W_EDGE = 2'd1;
    localparam logic [1:0] W_BASE = 2'd2;
    localparam logic [1:0] W_RUN  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [1:0]         r_edge, n_edge;
    logic [1:0]         r_last;
    carf_pkg::t_pix_op  r_op;
    logic [XW-1:0]      r_x0, r_x1, r_cx;
    logic [YW-1:0]      r_y0, r_y1, r_cy;
    logic [AW-1:0]      r_row;

    logic signed [13:0] xs, ys, ws, hs;
    logic signed [13:0] ex, ey, ew, eh;
    logic signed [14:0] ex_w, ey_w, x_lo, y_lo, x_hi, y_hi;
    logic               empty, last_edge, take, no_work;
    logic               col_end, row_end;

    // Command fields, sign extended
    assign xs = {{2{i_cmd.origin_x[11]}}, i_cmd.origin_x};
    assign ys = {{2{i_cmd.origin_y[11]}}, i_cmd.origin_y};
    assign ws = {{2{i_cmd.rect_width[11]}}, i_cmd.rect_width};
    assign hs = {{2{i_cmd.rect_height[11]}}, i_cmd.rect_height};

    // Current edge rectangle: fill and read use edge 0 only
    always_comb begin
        unique case (r_edge)
            2'd0: begin
                ex = xs;
                ey = ys;
                ew = (i_cmd.action == carf_pkg::ACT_READ) ? 14'sd1 : ws;
                eh = (i_cmd.action == carf_pkg::ACT_FILL) ? hs : 14'sd1;
            end
            2'd1: begin
                ex = xs;
                ey = ys + hs;
                ew = ws;
                eh = 14'sd1;
            end
            2'd2: begin
                ex = xs;
                ey = ys;
                ew = 14'sd1;
                eh = hs;
            end
            default: begin
                ex = xs + ws;
                ey = ys;
                ew = 14'sd1;
                eh = hs;
            end
        endcase
    end

    // Clip to the frame, exclusive upper bounds
    always_comb begin
        ex_w  = {ex[13], ex};
        ey_w  = {ey[13], ey};
        x_lo  = ex[13] ? 15'sd0 : ex_w;
        y_lo  = ey[13] ? 15'sd0 : ey_w;
        x_hi  = ex_w + {ew[13], ew};
        y_hi  = ey_w + {eh[13], eh};
        if (x_hi > FwS) begin
            x_hi = FwS;
        end
        if (y_hi > FhS) begin
            y_hi = FhS;
        end
        empty = (ew <= 14'sd0) || (eh <= 14'sd0) || (x_lo >= x_hi) || (y_lo >= y_hi);
    end

    assign last_edge = (r_edge == r_last);
    assign take      = (r_state == W_RUN) && i_pix_sts.ready;
    assign col_end   = ((r_cx + XW'(1)) == r_x1);
    assign row_end   = ((r_cy + YW'(1)) == r_y1);
    assign no_work   = (i_cmd.action == carf_pkg::ACT_RESERVED) ||
                       ((i_cmd.action != carf_pkg::ACT_READ) && (i_cmd.opacity == 8'd0));

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_edge  = r_edge;
        unique case (r_state)
            W_IDLE: begin
                if (i_start && !no_work) begin
                    n_state = W_EDGE;
                    n_edge  = 2'd0;
                end
            end
            W_EDGE: begin
                if (!empty) begin
                    n_state = W_BASE;
                end else if (last_edge) begin
                    n_state = W_IDLE;
                end else begin
                    n_edge = r_edge + 2'd1;
                end
            end
            W_BASE: begin
                n_state = W_RUN;
            end
            default: begin
                if (take && col_end && row_end) begin
                    if (last_edge) begin
                        n_state = W_IDLE;
                    end else begin
                        n_state = W_EDGE;
                        n_edge  = r_edge + 2'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
            r_edge  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_edge  <= n_edge;
        end
    end

    // Per-command setup, bounds and raster position
    always_ff @(posedge i_clk) begin
        if (r_state == W_IDLE && i_start) begin
            r_last <= (i_cmd.action == carf_pkg::ACT_OUTLINE) ? 2'd3 : 2'd0;
            if (i_cmd.action == carf_pkg::ACT_READ) begin
                r_op <= carf_pkg::OP_READ;
            end else if (i_cmd.opacity > carf_pkg::ALPHA_OPAQUE) begin
                r_op <= carf_pkg::OP_WRITE;
            end else begin
                r_op <= carf_pkg::OP_BLEND;
            end
        end
        if (r_state == W_EDGE) begin
            r_x0 <= XW'(x_lo);
            r_x1 <= XW'(x_hi);
            r_y0 <= YW'(y_lo);
            r_y1 <= YW'(y_hi);
        end
        if (r_state == W_BASE) begin
            r_row <= AW'(AW'(r_y0) * AW'(FRAME_WIDTH));
            r_cx  <= r_x0;
            r_cy  <= r_y0;
        end
        if (take) begin
            if (col_end) begin
                r_cx  <= r_x0;
                r_cy  <= r_cy + YW'(1);
                r_row <= r_row + AW'(FRAME_WIDTH);
            end else begin
                r_cx <= r_cx + XW'(1);
            end
        end
    end

    assign o_busy      = (r_state != W_IDLE);
    assign o_ctl.valid = (r_state == W_RUN);
    assign o_ctl.op    = r_op;
    assign o_addr      = r_row + AW'(r_cx);

endmodule

/* sv/carf_pix.sv */
// Pixel engine: replace, read-modify-write blend and pixel read on the frame store.
// Depends on carf_pkg; drives the ports of one carf_ram.
`timescale 1ns / 1ps

module carf_pix #(
    parameter int ADDR_W = 17
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  carf_pkg::t_pix_ctl i_ctl,
    input  logic [ADDR_W-1:0]  i_addr,
    input  carf_pkg::t_paint   i_paint,
    input  logic [15:0]        i_rdata,
    output carf_pkg::t_pix_sts o_sts,
    output logic               o_we,
    output logic [ADDR_W-1:0]  o_waddr,
    output logic [15:0]        o_wdata,
    output logic               o_re,
    output logic [ADDR_W-1:0]  o_raddr
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_WR   = 2'd2;
    localparam logic [1:0] P_RD   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_addr;
    logic [13:0]       r_sr, r_sg, r_sb;
    logic [13:0]       n_sr, n_sg, n_sb;
    logic [7:0]        inv;
    logic              take;
    carf_pkg::t_rgb565 old_px, blend_px;

    // One request at a time: a blend finishes its write before the next read
    assign take   = (r_state == P_IDLE) && i_ctl.valid;
    assign old_px = carf_pkg::t_rgb565'(i_rdata);
    assign inv    = carf_pkg::ALPHA_FULL - i_paint.alpha;

    // Blend sums, per channel c*a + old*(255-a)
    assign n_sr = 14'(i_paint.color.red) * 14'(i_paint.alpha) + 14'(old_px.red) * 14'(inv);
    assign n_sg = 14'(i_paint.color.green) * 14'(i_paint.alpha)
                + 14'(old_px.green) * 14'(inv);
    assign n_sb = 14'(i_paint.color.blue) * 14'(i_paint.alpha)
                + 14'(old_px.blue) * 14'(inv);

    assign blend_px.red   = 5'(carf_pkg::div255(r_sr));
    assign blend_px.green = 6'(carf_pkg::div255(r_sg));
    assign blend_px.blue  = 5'(carf_pkg::div255(r_sb));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            P_IDLE: begin
                if (take) begin
                    unique case (i_ctl.op)
                        carf_pkg::OP_BLEND: n_state = P_MUL;
                        carf_pkg::OP_READ:  n_state = P_RD;
                        default:            n_state = P_IDLE;
                    endcase
                end
            end
            P_MUL:   n_state = P_WR;
            P_WR:    n_state = P_IDLE;
            default: n_state = P_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_addr <= i_addr;
        end
        if (r_state == P_MUL) begin
            r_sr <= n_sr;
            r_sg <= n_sg;
            r_sb <= n_sb;
        end
    end

    // Memory port control
    assign o_re    = take && ((i_ctl.op == carf_pkg::OP_BLEND) || (i_ctl.op == carf_pkg::OP_READ));
    assign o_raddr = i_addr;
    assign o_we    = (take && (i_ctl.op == carf_pkg::OP_WRITE)) || (r_state == P_WR);
    assign o_waddr = (r_state == P_WR) ? r_addr : i_addr;
    assign o_wdata = (r_state == P_WR) ? 16'(blend_px) : 16'(i_paint.color);

    assign o_sts.ready    = (r_state == P_IDLE);
    assign o_sts.rd_valid = (r_state == P_RD);
    assign o_sts.rd_pixel = old_px;

endmodule

/* sv/clipped_alpha_rect_fill_engine_top.sv */
// Top level of the clipped alpha rectangle fill engine on an RGB565 frame store.
// Depends on carf_pkg, carf_walk, carf_pix and carf_ram.
//
//  channel   direction  handshake                    word
//  command   in         i_in_valid / o_in_stall      action, origin, size, color, opacity
//  result    out        o_out_valid / i_out_stall    read color, read_inside
//
// One command at a time. An accepted command is registered and handed to the walker; per edge
// it clips, then sets up when something is left, then writes each replaced pixel in its
// handshake or reads, multiplies and writes each blended pixel on the frame store port, or
// reads the pixel for a read; alpha 0 or an unused code starts no walk, an empty edge only clips.
// Reset is synchronous and clears control only; the frame store is undefined until written.
// A stalled result holds; the next command is accepted while it waits but cannot finish.
`timescale 1ns / 1ps

module clipped_alpha_rect_fill_engine_top #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic signed [11:0] i_origin_x,
    input  logic signed [11:0] i_origin_y,
    input  logic signed [11:0] i_rect_width,
    input  logic signed [11:0] i_rect_height,
    input  logic [4:0]         i_color_red,
    input  logic [5:0]         i_color_green,
    input  logic [4:0]         i_color_blue,
    input  logic [7:0]         i_opacity,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [4:0]         o_read_red,
    output logic [5:0]         o_read_green,
    output logic [4:0]         o_read_blue,
    output logic               o_read_inside
);

    localparam int Depth = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(Depth);
    localparam logic signed [12:0] FwS = 13'(FRAME_WIDTH);
    localparam logic signed [12:0] FhS = 13'(FRAME_HEIGHT);

    logic               r_busy, r_start, r_out_valid;
    logic               r_inside;
    carf_pkg::t_cmd     r_cmd;
    carf_pkg::t_paint   r_paint;
    carf_pkg::t_rgb565  r_pixel;
    logic [4:0]         r_read_red;
    logic [5:0]         r_read_green;
    logic [4:0]         r_read_blue;
    logic               r_read_inside;

    logic               accept, done, walk_busy, hit, in_frame;
    carf_pkg::t_pix_ctl pix_ctl;
    carf_pkg::t_pix_sts pix_sts;
    logic [AW-1:0]      pix_addr, ram_waddr, ram_raddr;
    logic               ram_we, ram_re;
    logic [15:0]        ram_wdata, ram_rdata;

    assign accept = i_in_valid && !r_busy;
    // Command complete once walker and pixel engine drain and the result slot is free
    assign done   = r_busy && !r_start && !walk_busy && pix_sts.ready &&
                    (!r_out_valid || !i_out_stall);
    assign in_frame = ({i_origin_x[11], i_origin_x} < FwS) && !i_origin_x[11] &&
                      ({i_origin_y[11], i_origin_y} < FhS) && !i_origin_y[11];
    assign hit    = (r_cmd.action == carf_pkg::ACT_READ) && r_inside;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= accept;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command, paint and result words
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.action      <= i_action;
            r_cmd.origin_x    <= i_origin_x;
            r_cmd.origin_y    <= i_origin_y;
            r_cmd.rect_width  <= i_rect_width;
            r_cmd.rect_height <= i_rect_height;
            r_cmd.opacity     <= i_opacity;
            r_paint.color.red   <= i_color_red;
            r_paint.color.green <= i_color_green;
            r_paint.color.blue  <= i_color_blue;
            r_paint.alpha       <= i_opacity;
            r_inside            <= in_frame;
        end
        if (pix_sts.rd_valid) begin
            r_pixel <= pix_sts.rd_pixel;
        end
        if (done) begin
            r_read_red    <= hit ? r_pixel.red   : 5'd0;
            r_read_green  <= hit ? r_pixel.green : 6'd0;
            r_read_blue   <= hit ? r_pixel.blue  : 5'd0;
            r_read_inside <= hit;
        end
    end

    carf_walk #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_cmd     (r_cmd),
        .i_pix_sts (pix_sts),
        .o_busy    (walk_busy),
        .o_ctl     (pix_ctl),
        .o_addr    (pix_addr)
    );

    carf_pix #(
        .ADDR_W (AW)
    ) u_pix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (pix_ctl),
        .i_addr  (pix_addr),
        .i_paint (r_paint),
        .i_rdata (ram_rdata),
        .o_sts   (pix_sts),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_wdata (ram_wdata),
        .o_re    (ram_re),
        .o_raddr (ram_raddr)
    );

    carf_ram #(
        .WIDTH (16),
        .DEPTH (Depth)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall    = r_busy;
    assign o_out_valid   = r_out_valid;
    assign o_read_red    = r_read_red;
    assign o_read_green  = r_read_green;
    assign o_read_blue   = r_read_blue;
    assign o_read_inside = r_read_inside;

endmodule

/* sv/carf_port_check.sv */
// Port-level checker for the fill engine, bound to the top level.
// Depends on clipped_alpha_rect_fill_engine_top_assert.svh.
`timescale 1ns / 1ps
`include "clipped_alpha_rect_fill_engine_top_assert.svh"

module carf_port_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [4:0] o_read_red,
    input logic [5:0] o_read_green,
    input logic [4:0] o_read_blue,
    input logic       o_read_inside
);

    // A stalled result word stays valid
    `CARF_ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // A stalled result word keeps its payload
    `CARF_ASSERT_NEXT(a_out_data_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_read_red) && $stable(o_read_green) && $stable(o_read_blue) && $stable(o_read_inside))

    // Drawing commands and misses report an all-zero color
    `CARF_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, o_out_valid && !o_read_inside, o_read_red == 5'd0 && o_read_green == 6'd0 && o_read_blue == 5'd0)

    // A command in flight blocks the next one
    `CARF_ASSERT_NEXT(a_one_cmd, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind clipped_alpha_rect_fill_engine_top carf_port_check u_port_check (.*);
